// ----- hdl/scq_pkg.sv -----
// Shared constants, codes and types for the searchable circular queue.
package scq_pkg;

  localparam int SLOTS = 8;
  localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORD_W = 32;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_OUT_W = 3;

  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

  // Search chain passed from each cell to the next higher one.
  typedef struct packed {
    logic hi_seen;   // a match at or above head was seen lower in the row
    logic any_seen;  // any match was seen lower in the row
  } chain_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ----- hdl/scq_cell.sv -----
// One queue slot: stored word, occupancy test, compare and search-chain stage.
module scq_cell (
  input  logic                        clk,
  input  logic [scq_pkg::PTR_W-1:0]   index,
  input  logic [scq_pkg::PTR_W-1:0]   head,
  input  logic [scq_pkg::PTR_W-1:0]   tail,
  input  logic                        wr_en,
  input  logic [scq_pkg::WORD_W-1:0]  wr_data,
  input  logic [scq_pkg::WORD_W-1:0]  key,
  input  logic                        hi_any,
  input  scq_pkg::chain_t             chain_in,
  output scq_pkg::chain_t             chain_out,
  output logic [scq_pkg::WORD_W-1:0]  entry,
  output logic                        hit
);
  import scq_pkg::*;

  logic at_or_above_head;
  logic occupied;
  logic match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  assign at_or_above_head = (index >= head);

  // Occupied slots run from head up to, not including, tail, wrapping.
  always_comb begin
    if (head <= tail) begin
      occupied = at_or_above_head && (index < tail);
    end else begin
      occupied = at_or_above_head || (index < tail);
    end
  end

  assign match = occupied && (entry == key);

  assign chain_out.hi_seen = chain_in.hi_seen | (match & at_or_above_head);
  assign chain_out.any_seen = chain_in.any_seen | match;

  // First from front: lowest match at or above head, else lowest wrapped match.
  assign hit = match & ((at_or_above_head & ~chain_in.hi_seen) |
                        (~hi_any & ~chain_in.any_seen));

endmodule

// ----- hdl/searchable_circular_queue_top.sv -----
// Top level of the searchable circular queue: pointers, cell row, result register.
//
// Searchable circular queue of signed 32-bit words, SLOTS slots with one slot
// always left empty, so it holds at most SLOTS-1 words.
//
// Command channel: drive mode and value with start high; the item is taken at
// the rising edge where start is high and busy is low. busy is always low, so
// a new item can be issued in every cycle.
//   mode 0 enqueue value, mode 1 dequeue front, mode 2 find value, 3 no-op.
// Result channel: one result per item, shown for exactly one cycle with done
// high, on the cycle right after the item was taken (throughput one item per
// cycle). The receiver cannot stall; it must capture on done.
//   status: ok, full on enqueue, empty on dequeue or find.
//   front_value, is_empty, is_full: queue state after the item.
//   found, found_slot: array slot of the first match counted from the front.
// The whole operation, including the search, is combinational up to the result
// registers: each cell compares its word in parallel and a two-bit chain through
// the row of cells picks the first match; that chain sets the critical path.
// Reset (rst, synchronous) empties the queue and clears done; stored words are
// not cleared, since a slot is only ever read after it has been written.
module searchable_circular_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [scq_pkg::MODE_W-1:0]         mode,
  input  logic signed [scq_pkg::WORD_W-1:0]  value,
  output logic                               done,
  output logic [scq_pkg::STATUS_W-1:0]       status,
  output logic signed [scq_pkg::WORD_W-1:0]  front_value,
  output logic                               is_empty,
  output logic                               is_full,
  output logic                               found,
  output logic [scq_pkg::SLOT_OUT_W-1:0]     found_slot
);
  import scq_pkg::*;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_next;

  logic [WORD_W-1:0] entries [SLOTS];
  logic [SLOTS-1:0] hits;
  chain_t chain [SLOTS+1];
  logic hi_any;

  logic accept;
  logic cur_empty;
  logic cur_full;
  logic do_enq;
  logic do_deq;
  logic do_find;

  logic [STATUS_W-1:0] status_next;
  logic [WORD_W-1:0] front_next;
  logic empty_next;
  logic full_next;
  logic found_next;
  logic [PTR_W-1:0] slot_enc;

  // Nothing stalls: the queue is always ready for the next item.
  assign busy = 1'b0;
  assign accept = start && !busy;

  assign cur_empty = (head == tail);
  assign cur_full = (next_slot(tail) == head);

  assign do_enq = accept && (mode == MODE_ENQ) && !cur_full;
  assign do_deq = accept && (mode == MODE_DEQ) && !cur_empty;
  assign do_find = accept && (mode == MODE_FIND) && !cur_empty;

  // Row of cells; the search chain runs from slot 0 upward.
  assign chain[0] = '0;
  assign hi_any = chain[SLOTS].hi_seen;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    scq_cell u_cell (
      .clk       (clk),
      .index     (PTR_W'(i)),
      .head      (head),
      .tail      (tail),
      .wr_en     (do_enq && (tail == PTR_W'(i))),
      .wr_data   (value),
      .key       (value),
      .hi_any    (hi_any),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .entry     (entries[i]),
      .hit       (hits[i])
    );
  end

  // hits is one-hot or zero, so an OR of the hit indexes encodes it.
  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hits[i]) begin
        slot_enc = slot_enc | PTR_W'(i);
      end
    end
  end

  assign head_next = do_deq ? next_slot(head) : head;
  assign tail_next = do_enq ? next_slot(tail) : tail;

  always_comb begin
    status_next = ST_OK;
    if (mode == MODE_ENQ && cur_full) begin
      status_next = ST_FULL;
    end else if ((mode inside {MODE_DEQ, MODE_FIND}) && cur_empty) begin
      status_next = ST_EMPTY;
    end
  end

  assign empty_next = (head_next == tail_next);
  assign full_next = (next_slot(tail_next) == head_next);
  assign found_next = do_find && (|hits);

  // Enqueue into an empty queue: the new word is the front before it lands.
  always_comb begin
    if (empty_next) begin
      front_next = '0;
    end else if (do_enq && cur_empty) begin
      front_next = value;
    end else begin
      front_next = entries[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      done <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      front_value <= front_next;
      is_empty <= empty_next;
      is_full <= full_next;
      found <= found_next;
      found_slot <= found_next ? SLOT_OUT_W'(slot_enc) : '0;
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_empty && is_full))
    else $error("queue reported empty and full at once");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == ST_OK)
    else $error("find hit reported with a failing status");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted item produced no result");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    done && is_empty |-> front_value == '0 && !found)
    else $error("empty queue reported a front word or a hit");
`endif

endmodule
